>>> hw/rtl/odgs_pkg.sv
// Shared widths, register map, reset values and interface structs of the gait scheduler.
package odgs_pkg;

    localparam int MAX_SEGMENTS = 32;
    localparam int LEG_COUNT    = 2;

    localparam int SEG_W   = 6;   // segments and durations
    localparam int OFF_W   = 5;   // offsets, row and segment indexes
    localparam int TPS_W   = 16;  // ticks per segment
    localparam int TICK_W  = 32;  // input tick count
    localparam int PER_W   = 21;  // ticks in one cycle, at most 32 * 65535
    localparam int FRAC_W  = 16;  // phase and progress fraction bits
    localparam int PROG_W  = FRAC_W + 1;
    localparam int DIV_W   = PER_W + FRAC_W;  // widest dividend
    localparam int REM_W   = PER_W + 1;
    localparam int STEP_W  = 6;   // divider step count, up to DIV_W
    localparam int PADDR_W = 5;
    localparam int PDATA_W = 32;

    localparam logic [SEG_W-1:0] RST_SEGMENTS = 6'd10;
    localparam logic [TPS_W-1:0] RST_TICKS    = 16'd1;
    localparam logic [OFF_W-1:0] RST_OFF0     = 5'd0;
    localparam logic [OFF_W-1:0] RST_OFF1     = 5'd5;
    localparam logic [SEG_W-1:0] RST_DUR0     = 6'd5;
    localparam logic [SEG_W-1:0] RST_DUR1     = 6'd5;

    typedef enum logic [2:0] {
        REG_SEGMENTS = 3'd0,
        REG_TICKS    = 3'd1,
        REG_OFF0     = 3'd2,
        REG_OFF1     = 3'd3,
        REG_DUR0     = 3'd4,
        REG_DUR1     = 3'd5
    } t_reg_idx;

    typedef struct packed {
        logic [SEG_W-1:0] segments;
        logic [TPS_W-1:0] ticks_per_segment;
        logic [OFF_W-1:0] first_leg_offset;
        logic [OFF_W-1:0] second_leg_offset;
        logic [SEG_W-1:0] first_leg_duration;
        logic [SEG_W-1:0] second_leg_duration;
    } t_cfg;

    typedef struct packed {
        logic              start;
        logic [STEP_W-1:0] steps;     // quotient bits to develop
        logic [DIV_W-1:0]  dividend;  // left-aligned
        logic [PER_W-1:0]  divisor;
    } t_div_req;

    typedef struct packed {
        logic             done;
        logic [DIV_W-1:0] quo;
        logic [PER_W-1:0] rem;
    } t_div_rsp;

endpackage

>>> hw/rtl/odgs_regs.sv
// APB configuration registers of the gait scheduler.
module odgs_regs import odgs_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    output t_cfg               o_cfg
);

    t_cfg     r_cfg;
    t_reg_idx reg_sel;

    assign reg_sel = t_reg_idx'(paddr[PADDR_W-1:2]);
    assign pready  = 1'b1;
    assign o_cfg   = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.segments            <= RST_SEGMENTS;
            r_cfg.ticks_per_segment   <= RST_TICKS;
            r_cfg.first_leg_offset    <= RST_OFF0;
            r_cfg.second_leg_offset   <= RST_OFF1;
            r_cfg.first_leg_duration  <= RST_DUR0;
            r_cfg.second_leg_duration <= RST_DUR1;
        end else if (psel && penable && pwrite) begin
            case (reg_sel)
                REG_SEGMENTS: r_cfg.segments            <= pwdata[SEG_W-1:0];
                REG_TICKS:    r_cfg.ticks_per_segment   <= pwdata[TPS_W-1:0];
                REG_OFF0:     r_cfg.first_leg_offset    <= pwdata[OFF_W-1:0];
                REG_OFF1:     r_cfg.second_leg_offset   <= pwdata[OFF_W-1:0];
                REG_DUR0:     r_cfg.first_leg_duration  <= pwdata[SEG_W-1:0];
                REG_DUR1:     r_cfg.second_leg_duration <= pwdata[SEG_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_sel)
            REG_SEGMENTS: prdata = PDATA_W'(r_cfg.segments);
            REG_TICKS:    prdata = PDATA_W'(r_cfg.ticks_per_segment);
            REG_OFF0:     prdata = PDATA_W'(r_cfg.first_leg_offset);
            REG_OFF1:     prdata = PDATA_W'(r_cfg.second_leg_offset);
            REG_DUR0:     prdata = PDATA_W'(r_cfg.first_leg_duration);
            REG_DUR1:     prdata = PDATA_W'(r_cfg.second_leg_duration);
            default:      prdata = '0;
        endcase
    end

endmodule

>>> hw/rtl/odgs_sdiv.sv
// Bit-serial restoring divider: one quotient bit per cycle.
module odgs_sdiv import odgs_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    logic              r_busy;
    logic              r_done;
    logic [STEP_W-1:0] r_cnt;
    logic [DIV_W-1:0]  r_quo;
    logic [PER_W-1:0]  r_rem;
    logic [PER_W-1:0]  r_dvs;

    logic [REM_W-1:0]  rem_sh;
    logic [REM_W-1:0]  rem_dif;
    logic              fits;

    // shift in the next dividend bit, subtract where the divisor fits
    assign rem_sh  = {r_rem, r_quo[DIV_W-1]};
    assign fits    = rem_sh >= {1'b0, r_dvs};
    assign rem_dif = rem_sh - {1'b0, r_dvs};

    assign o_rsp.done = r_done;
    assign o_rsp.quo  = r_quo;
    assign o_rsp.rem  = r_rem;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= i_req.steps;
                r_quo  <= i_req.dividend;
                r_rem  <= '0;
                r_dvs  <= i_req.divisor;
            end else if (r_busy) begin
                r_rem <= fits ? rem_dif[PER_W-1:0] : rem_sh[PER_W-1:0];
                r_quo <= {r_quo[DIV_W-2:0], fits};
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == STEP_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

endmodule

>>> hw/rtl/odgs_core.sv
// Sequencer: cycle arithmetic on the shared divider, then one table row per cycle unless stalled.
module odgs_core import odgs_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cfg              i_cfg,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic [TICK_W-1:0] i_tick_count,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic [OFF_W-1:0]  o_row_index,
    output logic              o_first_leg_stance,
    output logic              o_second_leg_stance,
    output logic [OFF_W-1:0]  o_gait_segment,
    output logic [FRAC_W-1:0] o_phase_fraction,
    output logic [PROG_W-1:0] o_first_leg_contact,
    output logic [PROG_W-1:0] o_second_leg_contact,
    output logic [PROG_W-1:0] o_first_leg_swing,
    output logic [PROG_W-1:0] o_second_leg_swing,
    output logic              o_last_row
);

    typedef enum logic [2:0] {
        S_IDLE, S_PERIOD, S_ISSUE, S_WAIT, S_WIN_S, S_WIN_L, S_WIN_P, S_EMIT
    } t_state;

    typedef enum logic [3:0] {
        J_REM, J_SEG, J_PHASE, J_OFF0, J_OFF1, J_CON0, J_CON1, J_SWG0, J_SWG1
    } t_job;

    t_state r_state;
    t_job   r_job;

    logic [TICK_W-1:0] r_tick;
    logic [SEG_W-1:0]  r_n;
    logic [TPS_W-1:0]  r_t;
    logic [SEG_W-1:0]  r_dur0, r_dur1;
    logic [OFF_W-1:0]  r_off0, r_off1;
    logic [PER_W-1:0]  r_period, r_r, r_s, r_len, r_p;
    logic [OFF_W-1:0]  r_seg;
    logic [FRAC_W-1:0] r_phase;
    logic [PROG_W-1:0] r_con0, r_con1, r_swg0, r_swg1;
    logic [OFF_W-1:0]  r_row, r_iter;
    logic              r_out_valid;

    t_div_req div_req;
    t_div_rsp div_rsp;

    // clamped configuration
    logic [SEG_W-1:0]  n_clamp, dur0_clamp, dur1_clamp;
    logic [TPS_W-1:0]  t_clamp;

    // leg window preparation
    logic              win_leg, win_swg, is_win, win_skip, job_end;
    logic [OFF_W-1:0]  off_l;
    logic [SEG_W-1:0]  dur_l, sum_l, start_f, len_f, mul_a;
    logic [SEG_W+TPS_W-1:0] prod;
    logic [REM_W-1:0]  p_wrap;
    logic [PROG_W-1:0] prog_val;

    // row generation
    logic [SEG_W-1:0]  seg_inc, iter_inc, pr0, pr1;
    logic [OFF_W-1:0]  iter0, iter_nxt;
    logic              flag0, flag1, row_last, slot_free;

    assign n_clamp = (i_cfg.segments == '0) ? SEG_W'(1) :
                     (i_cfg.segments > SEG_W'(MAX_SEGMENTS)) ? SEG_W'(MAX_SEGMENTS) :
                     i_cfg.segments;
    assign t_clamp = (i_cfg.ticks_per_segment == '0) ? TPS_W'(1) : i_cfg.ticks_per_segment;
    assign dur0_clamp = (i_cfg.first_leg_duration > n_clamp) ? n_clamp :
                        i_cfg.first_leg_duration;
    assign dur1_clamp = (i_cfg.second_leg_duration > n_clamp) ? n_clamp :
                        i_cfg.second_leg_duration;

    assign win_leg = (r_job == J_CON1) || (r_job == J_SWG1);
    assign win_swg = (r_job == J_SWG0) || (r_job == J_SWG1);
    assign is_win  = r_job >= J_CON0;
    assign off_l   = win_leg ? r_off1 : r_off0;
    assign dur_l   = win_leg ? r_dur1 : r_dur0;
    assign sum_l   = {1'b0, off_l} + dur_l;
    // swing starts where stance ends, wrapped into the cycle
    assign start_f = win_swg ? ((sum_l > r_n) ? sum_l - r_n : sum_l) : {1'b0, off_l};
    assign len_f   = win_swg ? r_n - dur_l : dur_l;

    always_comb begin
        case (r_state)
            S_PERIOD: mul_a = r_n;
            S_WIN_S:  mul_a = start_f;
            default:  mul_a = len_f;
        endcase
    end

    assign prod   = mul_a * r_t;
    assign p_wrap = ({1'b0, r_r} >= {1'b0, r_s}) ? {1'b0, r_r} - {1'b0, r_s} :
                    {1'b0, r_r} + {1'b0, r_period} - {1'b0, r_s};

    // an empty window, or a position past its end, gives zero without a division
    assign win_skip = (r_len == '0) || (r_p > r_len);
    assign job_end  = ((r_state == S_WAIT) && div_rsp.done) ||
                      ((r_state == S_ISSUE) && is_win && win_skip);
    assign prog_val = (r_state == S_WAIT) ? div_rsp.quo[PROG_W-1:0] : '0;

    always_comb begin
        div_req.start    = (r_state == S_ISSUE) && !(is_win && win_skip);
        div_req.steps    = STEP_W'(DIV_W);
        div_req.dividend = {r_p, {FRAC_W{1'b0}}};
        div_req.divisor  = r_len;
        case (r_job)
            J_REM: begin
                div_req.steps    = STEP_W'(TICK_W);
                div_req.dividend = {r_tick, {(DIV_W-TICK_W){1'b0}}};
                div_req.divisor  = r_period;
            end
            J_SEG: begin
                div_req.steps    = STEP_W'(PER_W);
                div_req.dividend = {r_r, {FRAC_W{1'b0}}};
                div_req.divisor  = PER_W'(r_t);
            end
            J_PHASE: begin
                div_req.dividend = {r_r, {FRAC_W{1'b0}}};
                div_req.divisor  = r_period;
            end
            J_OFF0: begin
                div_req.steps    = STEP_W'(OFF_W);
                div_req.dividend = {i_cfg.first_leg_offset, {(DIV_W-OFF_W){1'b0}}};
                div_req.divisor  = PER_W'(r_n);
            end
            J_OFF1: begin
                div_req.steps    = STEP_W'(OFF_W);
                div_req.dividend = {i_cfg.second_leg_offset, {(DIV_W-OFF_W){1'b0}}};
                div_req.divisor  = PER_W'(r_n);
            end
            default: ;
        endcase
    end

    odgs_sdiv u_sdiv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    // first row shows the segment after the current one
    assign seg_inc  = {1'b0, r_seg} + 1'b1;
    assign iter0    = (seg_inc == r_n) ? '0 : seg_inc[OFF_W-1:0];
    assign iter_inc = {1'b0, r_iter} + 1'b1;
    assign iter_nxt = (iter_inc == r_n) ? '0 : iter_inc[OFF_W-1:0];
    assign pr0 = (r_iter >= r_off0) ? {1'b0, r_iter} - {1'b0, r_off0} :
                 {1'b0, r_iter} + r_n - {1'b0, r_off0};
    assign pr1 = (r_iter >= r_off1) ? {1'b0, r_iter} - {1'b0, r_off1} :
                 {1'b0, r_iter} + r_n - {1'b0, r_off1};
    assign flag0    = pr0 < r_dur0;
    assign flag1    = pr1 < r_dur1;
    assign row_last = {1'b0, r_row} == r_n - 1'b1;
    assign slot_free = !r_out_valid || i_out_ready;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_job       <= J_REM;
            r_out_valid <= 1'b0;
            r_row       <= '0;
        end else begin
            // the emit state refills the output register on its own
            if (i_out_ready && (r_state != S_EMIT)) begin
                r_out_valid <= 1'b0;
            end
            if (job_end) begin
                case (r_job)
                    J_REM:   r_r     <= div_rsp.rem;
                    J_SEG:   r_seg   <= div_rsp.quo[OFF_W-1:0];
                    J_PHASE: r_phase <= div_rsp.quo[FRAC_W-1:0];
                    J_OFF0:  r_off0  <= div_rsp.rem[OFF_W-1:0];
                    J_OFF1:  r_off1  <= div_rsp.rem[OFF_W-1:0];
                    J_CON0:  r_con0  <= prog_val;
                    J_CON1:  r_con1  <= prog_val;
                    J_SWG0:  r_swg0  <= prog_val;
                    J_SWG1:  r_swg1  <= prog_val;
                    default: ;
                endcase
            end
            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_tick  <= i_tick_count;
                        r_n     <= n_clamp;
                        r_t     <= t_clamp;
                        r_dur0  <= dur0_clamp;
                        r_dur1  <= dur1_clamp;
                        r_state <= S_PERIOD;
                    end
                end
                S_PERIOD: begin
                    r_period <= prod[PER_W-1:0];
                    r_job    <= J_REM;
                    r_state  <= S_ISSUE;
                end
                S_ISSUE, S_WAIT: begin
                    if (job_end) begin
                        if (r_job == J_SWG1) begin
                            r_row   <= '0;
                            r_iter  <= iter0;
                            r_state <= S_EMIT;
                        end else begin
                            r_job   <= t_job'(r_job + 1'b1);
                            r_state <= (r_job >= J_OFF1) ? S_WIN_S : S_ISSUE;
                        end
                    end else if (r_state == S_ISSUE) begin
                        r_state <= S_WAIT;
                    end
                end
                S_WIN_S: begin
                    r_s     <= prod[PER_W-1:0];
                    r_state <= S_WIN_L;
                end
                S_WIN_L: begin
                    r_len   <= prod[PER_W-1:0];
                    r_state <= S_WIN_P;
                end
                S_WIN_P: begin
                    r_p     <= p_wrap[PER_W-1:0];
                    r_state <= S_ISSUE;
                end
                S_EMIT: begin
                    if (slot_free) begin
                        r_out_valid          <= 1'b1;
                        o_row_index          <= r_row;
                        o_first_leg_stance   <= flag0;
                        o_second_leg_stance  <= flag1;
                        o_gait_segment       <= r_seg;
                        o_phase_fraction     <= r_phase;
                        o_first_leg_contact  <= r_con0;
                        o_second_leg_contact <= r_con1;
                        o_first_leg_swing    <= r_swg0;
                        o_second_leg_swing   <= r_swg1;
                        o_last_row           <= row_last;
                        r_row                <= r_row + 1'b1;
                        r_iter               <= iter_nxt;
                        if (row_last) begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

>>> hw/rtl/offset_duration_gait_scheduler_unit.sv
// Top level of the offset/duration gait scheduler: register port and table sequencer.
//
// Usage:
//   Input channel (i_in_valid / o_in_ready) takes one item: a controller tick
//   count. For that item the block returns one item per gait segment on the
//   output channel (o_out_valid / i_out_ready), rows 0 to n-1, where row 0 is
//   the segment after the current one and o_last_row marks row n-1. Every row
//   repeats the current segment, the cycle phase and each leg's contact and
//   swing progress in Q1.16.
//   Configuration sits behind an APB-style port, one register per 4 bytes;
//   write it only while the block is idle.
// Divisions and throughput:
//   One shared restoring divider develops one quotient bit per cycle and does
//   up to nine divisions in turn: tick mod period (32 steps), segment (21),
//   phase (37), two offset reductions (5 each) and up to four leg windows
//   (37 each, after setup states for start, length and position; a window is
//   skipped when it is empty or its position lies past its end). Rows then
//   leave one per cycle while i_out_ready stays high.
// Reset: synchronous, active low; registers return to their defaults and
//   the sequencer drops any item in flight.
// Stall: a row waits in the output register while i_out_ready is low, and the
//   sequencer holds; the last row may wait while the next item is accepted.
module offset_duration_gait_scheduler_unit import odgs_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // configuration port
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    // input channel
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [TICK_W-1:0]  i_tick_count,
    // output channel
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [OFF_W-1:0]   o_row_index,
    output logic               o_first_leg_stance,
    output logic               o_second_leg_stance,
    output logic [OFF_W-1:0]   o_gait_segment,
    output logic [FRAC_W-1:0]  o_phase_fraction,
    output logic [PROG_W-1:0]  o_first_leg_contact,
    output logic [PROG_W-1:0]  o_second_leg_contact,
    output logic [PROG_W-1:0]  o_first_leg_swing,
    output logic [PROG_W-1:0]  o_second_leg_swing,
    output logic               o_last_row
);

    t_cfg cfg;

    // register file: live configuration, read back over APB
    odgs_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // sequencer: clamp the configuration at acceptance, run the divisions,
    // then stream the table through the output register
    odgs_core u_core (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_cfg                (cfg),
        .i_in_valid           (i_in_valid),
        .o_in_ready           (o_in_ready),
        .i_tick_count         (i_tick_count),
        .o_out_valid          (o_out_valid),
        .i_out_ready          (i_out_ready),
        .o_row_index          (o_row_index),
        .o_first_leg_stance   (o_first_leg_stance),
        .o_second_leg_stance  (o_second_leg_stance),
        .o_gait_segment       (o_gait_segment),
        .o_phase_fraction     (o_phase_fraction),
        .o_first_leg_contact  (o_first_leg_contact),
        .o_second_leg_contact (o_second_leg_contact),
        .o_first_leg_swing    (o_first_leg_swing),
        .o_second_leg_swing   (o_second_leg_swing),
        .o_last_row           (o_last_row)
    );

endmodule

>>> hw/rtl/odgs_checker.sv
// Port-level checks on the gait scheduler, bound to its top level.
module odgs_checker import odgs_pkg::*; (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_in_ready,
    input logic               o_out_valid,
    input logic               i_out_ready,
    input logic [OFF_W-1:0]   o_row_index,
    input logic [FRAC_W-1:0]  o_phase_fraction,
    input logic [PROG_W-1:0]  o_first_leg_contact,
    input logic [PROG_W-1:0]  o_second_leg_contact,
    input logic [PROG_W-1:0]  o_first_leg_swing,
    input logic [PROG_W-1:0]  o_second_leg_swing,
    input logic               o_last_row
);

    // a stalled row holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=>
            o_out_valid && $stable(o_row_index) && $stable(o_phase_fraction))
        else $error("stalled row changed");

    // no new tick is taken while a table is still being emitted
    a_table_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_last_row |-> !o_in_ready)
        else $error("tick accepted during an unfinished table");

    // rows of one table leave back to back
    a_row_stream: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_ready && !o_last_row |=>
            o_out_valid && (o_row_index == $past(o_row_index) + 1'b1))
        else $error("gap or skip inside a table");

    // a leg is never in stance and swing progress at once
    a_leg_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |->
            !((o_first_leg_contact != '0) && (o_first_leg_swing != '0)) &&
            !((o_second_leg_contact != '0) && (o_second_leg_swing != '0)))
        else $error("contact and swing progress both active");

endmodule

bind offset_duration_gait_scheduler_unit odgs_checker u_odgs_checker (.*);

>>> verif/offset_duration_gait_scheduler_unit_checker.sv
`timescale 1ns / 1ps
// Gait table checker: follows register writes, predicts the rows of every tick and compares them.
module offset_duration_gait_scheduler_unit_checker import odgs_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_psel,
    input  logic               i_penable,
    input  logic               i_pwrite,
    input  logic               i_pready,
    input  logic [PADDR_W-1:0] i_paddr,
    input  logic [PDATA_W-1:0] i_pwdata,
    input  logic               i_in_valid,
    input  logic               i_in_ready,
    input  logic [TICK_W-1:0]  i_tick_count,
    input  logic               i_out_valid,
    input  logic               i_out_ready,
    input  logic [OFF_W-1:0]   i_row_index,
    input  logic               i_first_leg_stance,
    input  logic               i_second_leg_stance,
    input  logic [OFF_W-1:0]   i_gait_segment,
    input  logic [FRAC_W-1:0]  i_phase_fraction,
    input  logic [PROG_W-1:0]  i_first_leg_contact,
    input  logic [PROG_W-1:0]  i_second_leg_contact,
    input  logic [PROG_W-1:0]  i_first_leg_swing,
    input  logic [PROG_W-1:0]  i_second_leg_swing,
    input  logic               i_last_row,
    output int                 o_fail_count,
    output int                 o_rows_pending,
    output int                 o_rows_checked
);

    typedef struct packed {
        logic [OFF_W-1:0]  row_index;
        logic              first_stance;
        logic              second_stance;
        logic [OFF_W-1:0]  segment;
        logic [FRAC_W-1:0] phase;
        logic [PROG_W-1:0] first_contact;
        logic [PROG_W-1:0] second_contact;
        logic [PROG_W-1:0] first_swing;
        logic [PROG_W-1:0] second_swing;
        logic              last_row;
    } t_gait_row;

    localparam int REPORT_LIMIT = 10;

    t_cfg      gait_cfg;
    t_gait_row table_rows[$];
    int        fail_count   = 0;
    int        pending_rows = 0;
    int        rows_checked = 0;

    assign o_fail_count   = fail_count;
    assign o_rows_pending = pending_rows;
    assign o_rows_checked = rows_checked;

    // Progress through a window of len ticks starting at start, wrapping by one cycle.
    function automatic longint unsigned window_progress(longint unsigned pos,
                                                        longint unsigned start,
                                                        longint unsigned len,
                                                        longint unsigned period);
        longint unsigned p;
        p = (pos >= start) ? pos - start : pos + period - start;
        if (len == 0 || p > len) return 0;
        return (p << FRAC_W) / len;
    endfunction

    function automatic string row_text(t_gait_row r);
        return $sformatf({"row=%0d stance=%b/%b seg=%0d phase=%0d ",
                          "contact=%0d/%0d swing=%0d/%0d last=%b"},
                         r.row_index, r.first_stance, r.second_stance, r.segment, r.phase,
                         r.first_contact, r.second_contact, r.first_swing, r.second_swing,
                         r.last_row);
    endfunction

    // Queue every row that one tick produces under the current settings.
    task automatic predict_tick_table(input logic [TICK_W-1:0] tick);
        longint unsigned n, t, period, pos, seg, phase, so, iter, rel;
        longint unsigned off_raw[LEG_COUNT], dur_raw[LEG_COUNT];
        longint unsigned off[LEG_COUNT], dur[LEG_COUNT];
        longint unsigned contact[LEG_COUNT], swing[LEG_COUNT];
        logic [LEG_COUNT-1:0] stance;
        t_gait_row row;
        n = gait_cfg.segments;
        t = gait_cfg.ticks_per_segment;
        off_raw[0] = gait_cfg.first_leg_offset;
        off_raw[1] = gait_cfg.second_leg_offset;
        dur_raw[0] = gait_cfg.first_leg_duration;
        dur_raw[1] = gait_cfg.second_leg_duration;
        if (n == 0) n = 1;
        if (n > MAX_SEGMENTS) n = MAX_SEGMENTS;
        if (t == 0) t = 1;
        period = t * n;
        pos    = tick % period;
        seg    = (tick / t) % n;
        phase  = (pos << FRAC_W) / period;
        for (int j = 0; j < LEG_COUNT; j++) begin
            off[j]     = off_raw[j] % n;
            dur[j]     = (dur_raw[j] > n) ? n : dur_raw[j];
            contact[j] = window_progress(pos, off[j] * t, dur[j] * t, period);
            so         = (off[j] + dur[j]) * t;
            if (so > period) so -= period;
            swing[j]   = window_progress(pos, so, (n - dur[j]) * t, period);
        end
        for (longint unsigned i = 0; i < n; i++) begin
            iter = (i + seg + 1) % n;
            for (int j = 0; j < LEG_COUNT; j++) begin
                rel       = (iter >= off[j]) ? iter - off[j] : iter + n - off[j];
                stance[j] = (rel < dur[j]);
            end
            row.row_index      = i[OFF_W-1:0];
            row.first_stance   = stance[0];
            row.second_stance  = stance[1];
            row.segment        = seg[OFF_W-1:0];
            row.phase          = phase[FRAC_W-1:0];
            row.first_contact  = contact[0][PROG_W-1:0];
            row.second_contact = contact[1][PROG_W-1:0];
            row.first_swing    = swing[0][PROG_W-1:0];
            row.second_swing   = swing[1][PROG_W-1:0];
            row.last_row       = (i == n - 1);
            table_rows.push_back(row);
        end
    endtask

    always @(posedge i_clk) begin
        t_gait_row got;
        t_gait_row want;
        if (!i_rst_n) begin
            gait_cfg.segments            = RST_SEGMENTS;
            gait_cfg.ticks_per_segment   = RST_TICKS;
            gait_cfg.first_leg_offset    = RST_OFF0;
            gait_cfg.second_leg_offset   = RST_OFF1;
            gait_cfg.first_leg_duration  = RST_DUR0;
            gait_cfg.second_leg_duration = RST_DUR1;
            table_rows.delete();
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                case (i_paddr[PADDR_W-1:2])
                    REG_SEGMENTS: gait_cfg.segments            = i_pwdata[SEG_W-1:0];
                    REG_TICKS:    gait_cfg.ticks_per_segment   = i_pwdata[TPS_W-1:0];
                    REG_OFF0:     gait_cfg.first_leg_offset    = i_pwdata[OFF_W-1:0];
                    REG_OFF1:     gait_cfg.second_leg_offset   = i_pwdata[OFF_W-1:0];
                    REG_DUR0:     gait_cfg.first_leg_duration  = i_pwdata[SEG_W-1:0];
                    REG_DUR1:     gait_cfg.second_leg_duration = i_pwdata[SEG_W-1:0];
                    default: ;
                endcase
            end
            if (i_out_valid && i_out_ready) begin
                got = '{row_index: i_row_index, first_stance: i_first_leg_stance,
                        second_stance: i_second_leg_stance, segment: i_gait_segment,
                        phase: i_phase_fraction, first_contact: i_first_leg_contact,
                        second_contact: i_second_leg_contact, first_swing: i_first_leg_swing,
                        second_swing: i_second_leg_swing, last_row: i_last_row};
                if (table_rows.size() == 0) begin
                    fail_count++;
                    if (fail_count <= REPORT_LIMIT)
                        $display("%0t: unexpected row: %s", $realtime, row_text(got));
                end else begin
                    want = table_rows.pop_front();
                    rows_checked++;
                    if (got !== want) begin
                        fail_count++;
                        if (fail_count <= REPORT_LIMIT) begin
                            $display("%0t: row mismatch", $realtime);
                            $display("  expected %s", row_text(want));
                            $display("  actual   %s", row_text(got));
                        end
                    end
                end
            end
            if (i_in_valid && i_in_ready) predict_tick_table(i_tick_count);
        end
        pending_rows = table_rows.size();
    end

endmodule

>>> verif/offset_duration_gait_scheduler_unit_tb.sv
`timescale 1ns / 1ps
// Testbench top: drives ticks and register writes into the gait scheduler and gives the verdict.
module offset_duration_gait_scheduler_unit_tb;
    import odgs_pkg::*;

    // A tick runs all of its divisions before its first row, with no handshake in between;
    // the limit covers that plus sender gaps and receiver stalls.
    localparam int WATCHDOG_LIMIT  = 4000;
    localparam int TAIL_CYCLES     = 400;
    localparam int RANDOM_PHASES   = 8;
    localparam int TICKS_PER_PHASE = 22;
    localparam int IDLE_PCT        = 33;
    localparam int QUIET_PHASE     = 3;
    // register slot past the end of the map; writes to it must change nothing
    localparam logic [2:0] UNMAPPED_REG = 3'd6;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [PADDR_W-1:0] paddr = '0;
    logic [PDATA_W-1:0] pwdata = '0;
    logic [PDATA_W-1:0] prdata;
    logic               pready;
    logic               i_in_valid = 1'b0;
    logic               o_in_ready;
    logic [TICK_W-1:0]  i_tick_count = '0;
    logic               o_out_valid;
    logic               i_out_ready = 1'b0;
    logic [OFF_W-1:0]   o_row_index;
    logic               o_first_leg_stance;
    logic               o_second_leg_stance;
    logic [OFF_W-1:0]   o_gait_segment;
    logic [FRAC_W-1:0]  o_phase_fraction;
    logic [PROG_W-1:0]  o_first_leg_contact;
    logic [PROG_W-1:0]  o_second_leg_contact;
    logic [PROG_W-1:0]  o_first_leg_swing;
    logic [PROG_W-1:0]  o_second_leg_swing;
    logic               o_last_row;

    int fail_count;
    int rows_pending;
    int rows_checked;

    // stimulus bookkeeping
    int gap_pct       = IDLE_PCT;
    int stall_pct     = IDLE_PCT;
    int eff_segments  = 10;
    int eff_tps       = 1;
    int ticks_sent    = 0;
    int gait_settings = 1;
    int idle_cycles   = 0;

    offset_duration_gait_scheduler_unit dut (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .psel                 (psel),
        .penable              (penable),
        .pwrite               (pwrite),
        .paddr                (paddr),
        .pwdata               (pwdata),
        .prdata               (prdata),
        .pready               (pready),
        .i_in_valid           (i_in_valid),
        .o_in_ready           (o_in_ready),
        .i_tick_count         (i_tick_count),
        .o_out_valid          (o_out_valid),
        .i_out_ready          (i_out_ready),
        .o_row_index          (o_row_index),
        .o_first_leg_stance   (o_first_leg_stance),
        .o_second_leg_stance  (o_second_leg_stance),
        .o_gait_segment       (o_gait_segment),
        .o_phase_fraction     (o_phase_fraction),
        .o_first_leg_contact  (o_first_leg_contact),
        .o_second_leg_contact (o_second_leg_contact),
        .o_first_leg_swing    (o_first_leg_swing),
        .o_second_leg_swing   (o_second_leg_swing),
        .o_last_row           (o_last_row)
    );

    offset_duration_gait_scheduler_unit_checker table_check (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_psel               (psel),
        .i_penable            (penable),
        .i_pwrite             (pwrite),
        .i_pready             (pready),
        .i_paddr              (paddr),
        .i_pwdata             (pwdata),
        .i_in_valid           (i_in_valid),
        .i_in_ready           (o_in_ready),
        .i_tick_count         (i_tick_count),
        .i_out_valid          (o_out_valid),
        .i_out_ready          (i_out_ready),
        .i_row_index          (o_row_index),
        .i_first_leg_stance   (o_first_leg_stance),
        .i_second_leg_stance  (o_second_leg_stance),
        .i_gait_segment       (o_gait_segment),
        .i_phase_fraction     (o_phase_fraction),
        .i_first_leg_contact  (o_first_leg_contact),
        .i_second_leg_contact (o_second_leg_contact),
        .i_first_leg_swing    (o_first_leg_swing),
        .i_second_leg_swing   (o_second_leg_swing),
        .i_last_row           (o_last_row),
        .o_fail_count         (fail_count),
        .o_rows_pending       (rows_pending),
        .o_rows_checked       (rows_checked)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Receiver: stall at random on each falling edge; stall_pct of zero keeps it always ready.
    always @(negedge i_clk) begin
        i_out_ready <= ($urandom_range(0, 99) >= stall_pct);
    end

    // Watchdog: count cycles in which no item, row or register write gets through.
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) ||
            (psel && penable && pwrite && pready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
            $display("status: fail");
            $finish;
        end
    end

    // Write one register: setup cycle, then access cycle until pready.
    // Fill the bits above the field with noise, since the register must drop them.
    task automatic apb_write(input logic [PADDR_W-1:0] addr, input logic [PDATA_W-1:0] value,
                             input int field_w);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = addr;
        pwdata  = (PDATA_W'($urandom) << field_w) | value;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    // Load a full gait setting and remember its effective size for tick shaping.
    task automatic program_gait(input int segs, input int tps, input int off0, input int off1,
                                input int dur0, input int dur1);
        apb_write({REG_SEGMENTS, 2'b00}, segs, SEG_W);
        apb_write({REG_TICKS, 2'b00}, tps, TPS_W);
        apb_write({REG_OFF0, 2'b00}, off0, OFF_W);
        apb_write({REG_OFF1, 2'b00}, off1, OFF_W);
        apb_write({REG_DUR0, 2'b00}, dur0, SEG_W);
        apb_write({REG_DUR1, 2'b00}, dur1, SEG_W);
        eff_segments = (segs == 0) ? 1 : (segs > MAX_SEGMENTS) ? MAX_SEGMENTS : segs;
        eff_tps      = (tps == 0) ? 1 : tps;
        gait_settings++;
    endtask

    // Offer one tick; idle first at random, hold valid and payload until accepted.
    task automatic send_tick(input logic [TICK_W-1:0] tick);
        if ($urandom_range(0, 99) < gap_pct) begin
            i_in_valid = 1'b0;
            do @(negedge i_clk); while ($urandom_range(0, 99) < gap_pct);
        end
        i_in_valid   = 1'b1;
        i_tick_count = tick;
        do @(posedge i_clk); while (!o_in_ready);
        @(negedge i_clk);
        ticks_sent++;
    endtask

    // Drop valid and hold until every predicted row has come back.
    task automatic drain_rows();
        i_in_valid = 1'b0;
        while (rows_pending != 0) @(negedge i_clk);
    endtask

    // Pick a tick that lands near the interesting spots of the current cycle:
    // segment edges, window starts, the top of the 32-bit range, or anywhere.
    function automatic logic [TICK_W-1:0] pick_tick();
        longint unsigned per;
        longint unsigned base;
        per = longint'(eff_segments) * longint'(eff_tps);
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return TICK_W'($urandom_range(0, 3 * per));
            4: begin
                base = longint'($urandom_range(0, 2 * eff_segments)) * eff_tps;
                return TICK_W'(base + $urandom_range(0, 2) - 1);
            end
            5: begin
                base = longint'($urandom_range(0, 1000)) * per;
                return TICK_W'(base + longint'($urandom_range(0, eff_segments)) * eff_tps);
            end
            6, 7: return $urandom;
            8: return TICK_W'(32'hFFFF_FFFF - $urandom_range(0, per));
            default: return TICK_W'(per * $urandom_range(1, 2000) - 1);
        endcase
    endfunction

    initial begin
        int segs;
        int tps;
        int n;
        // Hold reset, then release it on a falling edge.
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Reset defaults: ten segments of one tick, legs half a cycle apart.
        send_tick(32'd0);
        send_tick(32'd4);
        send_tick(32'd5);
        send_tick(32'd9);
        send_tick(32'd10);
        send_tick(32'hFFFF_FFFF);
        drain_rows();

        // Zero segments and zero ticks fall back to one; offsets fold, durations clamp.
        // Then write past the register map and make sure nothing moves.
        program_gait(0, 0, 31, 31, 63, 63);
        apb_write({UNMAPPED_REG, 2'b00}, $urandom, 0);
        send_tick(32'd0);
        send_tick(32'h5555_5555);
        send_tick(32'hAAAA_AAAA);
        drain_rows();

        // Segments above the maximum, widest tick count; an empty stance window on
        // the first leg and an empty swing window on the second.
        program_gait(63, 65535, 31, 0, 0, 32);
        send_tick(32'd0);
        send_tick(32'd31 * 32'd65535);
        send_tick(32'd32 * 32'd65535 - 32'd1);
        send_tick(32'hFFFF_FFFF);
        drain_rows();

        // Offset not below segments, duration above segments, swing start past the cycle.
        program_gait(7, 3, 12, 6, 9, 4);
        send_tick(32'd0);
        send_tick(32'd15);
        send_tick(32'd20);
        send_tick(32'd21);
        drain_rows();

        // Full table of 32 rows, single-tick segments.
        program_gait(32, 1, 16, 0, 16, 0);
        send_tick(32'd0);
        send_tick(32'd16);
        send_tick(32'd31);
        send_tick(32'd32);
        drain_rows();

        // Random settings, mostly small tables; one phase runs with no idling at all.
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            segs = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 63) : $urandom_range(1, 12);
            case ($urandom_range(0, 5))
                0:       tps = 0;
                1:       tps = 65535;
                2:       tps = $urandom_range(1, 65535);
                default: tps = $urandom_range(1, 50);
            endcase
            n = (segs == 0) ? 1 : (segs > MAX_SEGMENTS) ? MAX_SEGMENTS : segs;
            program_gait(segs, tps, $urandom_range(0, 31), $urandom_range(0, 31),
                         ($urandom_range(0, 3) == 0) ? $urandom_range(0, 63)
                                                     : $urandom_range(0, n),
                         ($urandom_range(0, 3) == 0) ? $urandom_range(0, 63)
                                                     : $urandom_range(0, n));
            gap_pct   = (p == QUIET_PHASE) ? 0 : IDLE_PCT;
            stall_pct = (p == QUIET_PHASE) ? 0 : IDLE_PCT;
            for (int k = 0; k < TICKS_PER_PHASE; k++) send_tick(pick_tick());
            drain_rows();
        end

        // Let any stray rows surface before the verdict.
        repeat (TAIL_CYCLES) @(negedge i_clk);

        $display("ran %0d ticks over %0d gait settings", ticks_sent, gait_settings);
        $display("compared %0d table rows, %0d failures", rows_checked, fail_count);
        if (fail_count == 0 && rows_pending == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

>>> files.f
hw/rtl/odgs_pkg.sv
hw/rtl/odgs_regs.sv
hw/rtl/odgs_sdiv.sv
hw/rtl/odgs_core.sv
hw/rtl/offset_duration_gait_scheduler_unit.sv
hw/rtl/odgs_checker.sv
verif/offset_duration_gait_scheduler_unit_checker.sv
verif/offset_duration_gait_scheduler_unit_tb.sv
